// File: design/sam_pkg.sv
package sam_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned QUEUE_DEPTH    = 2;

  typedef struct packed {
    logic not_empty;
    logic not_full;
  } q_stat_t;

endpackage

// File: design/sam_queue.sv
module sam_queue #(
  parameter int unsigned WIDTH = 65,
  parameter int unsigned DEPTH = sam_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output sam_pkg::q_stat_t stat_o
);
  import sam_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.not_empty = (cnt_q != '0);
  assign stat_o.not_full  = (cnt_q != CntW'(DEPTH));
  assign do_push = push_i && stat_o.not_full;
  assign do_pop  = pop_i && stat_o.not_empty;
  assign rdata_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue count above depth");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a push");

endmodule

// File: design/sam_front.sv
module sam_front #(
  parameter int unsigned DATA_WIDTH = sam_pkg::DATA_WIDTH_DEF
) (
  input  logic [DATA_WIDTH-1:0] mul_i,
  input  logic [DATA_WIDTH-1:0] mcand_i,
  output logic [2*DATA_WIDTH:0] entry_o
);
  import sam_pkg::*;

  localparam int unsigned LenW = $clog2(DATA_WIDTH + 1);

  logic [LenW-1:0] len_a, len_b;
  logic [LenW:0]   len_sum;
  logic            ovf;

  function automatic logic [LenW-1:0] bit_len(input logic [DATA_WIDTH-1:0] v);
    logic [LenW-1:0] n;
    n = '0;
    for (int unsigned b = 0; b < DATA_WIDTH; b++) begin
      if (v[b]) begin
        n = LenW'(b + 1);
      end
    end
    return n;
  endfunction

  assign len_a   = bit_len(mul_i);
  assign len_b   = bit_len(mcand_i);
  assign len_sum = {1'b0, len_a} + {1'b0, len_b};
  assign ovf     = (len_sum >= (LenW + 1)'(DATA_WIDTH));
  assign entry_o = {ovf, mcand_i, mul_i};

endmodule

// File: design/sam_back.sv
module sam_back #(
  parameter int unsigned DATA_WIDTH = sam_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sam_pkg::q_stat_t      q_stat_i,
  input  logic [2*DATA_WIDTH:0] entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] product_o,
  output logic                  overflow_o
);
  import sam_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e                state_q, state_d;
  logic [DATA_WIDTH-1:0] m_q, m_d, s_q, s_d, acc_q, acc_d;
  logic [DATA_WIDTH-1:0] prod_q, prod_d;
  logic                  flag_q, flag_d;
  logic                  ov_q, ov_d;
  logic                  out_free;
  logic                  e_ovf;
  logic [DATA_WIDTH-1:0] e_mul, e_mcand;

  assign {e_ovf, e_mcand, e_mul} = entry_i;
  assign out_free = !ov_q || out_ready_i;
  assign pop_o    = (state_q == ST_IDLE) && q_stat_i.not_empty && out_free;

  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    s_d     = s_q;
    acc_d   = acc_q;
    prod_d  = prod_q;
    flag_d  = flag_q;
    ov_d    = ov_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          if (e_ovf) begin
            ov_d   = 1'b1;
            prod_d = '0;
            flag_d = 1'b1;
          end else begin
            m_d     = e_mul;
            s_d     = e_mcand;
            acc_d   = '0;
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (m_q == '0) begin
          if (out_free) begin
            ov_d    = 1'b1;
            prod_d  = acc_q;
            flag_d  = 1'b0;
            state_d = ST_IDLE;
          end
        end else begin
          if (m_q[0]) begin
            acc_d = acc_q + s_q;
          end
          s_d = {s_q[DATA_WIDTH-2:0], 1'b0};
          m_d = {1'b0, m_q[DATA_WIDTH-1:1]};
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    s_q    <= s_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    flag_q <= flag_d;
  end

  assign out_valid_o = ov_q;
  assign product_o   = prod_q;
  assign overflow_o  = flag_q;

  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && flag_q) |-> (prod_q == '0))
    else $error("overflow beat carries nonzero product");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ST_IDLE && q_stat_i.not_empty))
    else $error("pop outside idle");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> (ov_q && $stable(prod_q) && $stable(flag_q)))
    else $error("stalled result changed");

endmodule

// File: design/shift_add_multiplier_overflow_check_core.sv
// A beat flagged as overflow bypasses the shift-add loop; any other beat runs
// through the single shift-add loop in the back end, one multiplier bit per
// cycle over the bit length of the multiplier, while the queue can take new
// beats. Overflow beats go one per cycle while the output is not stalled.
// Reset: rst_ni is asynchronous, active low; it empties the queue and drops
// any pending result.
module shift_add_multiplier_overflow_check_core #(
  parameter int unsigned DATA_WIDTH = sam_pkg::DATA_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // [DATA_WIDTH-1:0] multiplier, [2*DATA_WIDTH-1:DATA_WIDTH] multiplicand
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // [DATA_WIDTH-1:0] product
  output logic [((DATA_WIDTH+7)/8)*8-1:0]        m_axis_tdata_o,
  // [0] overflow
  output logic                                   m_axis_tuser_o
);
  import sam_pkg::*;

  localparam int unsigned EntryW  = 2 * DATA_WIDTH + 1;
  localparam int unsigned OutBits = ((DATA_WIDTH + 7) / 8) * 8;

  logic [EntryW-1:0]     f_entry, q_entry;
  q_stat_t               q_stat;
  logic                  q_pop;
  logic [DATA_WIDTH-1:0] product;

  sam_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .mul_i   (s_axis_tdata_i[DATA_WIDTH-1:0]),
    .mcand_i (s_axis_tdata_i[2*DATA_WIDTH-1:DATA_WIDTH]),
    .entry_o (f_entry)
  );

  sam_queue #(
    .WIDTH(EntryW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid_i),
    .wdata_i (f_entry),
    .pop_i   (q_pop),
    .rdata_o (q_entry),
    .stat_o  (q_stat)
  );

  assign s_axis_tready_o = q_stat.not_full;

  sam_back #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .entry_i     (q_entry),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .product_o   (product),
    .overflow_o  (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = OutBits'(product);

endmodule
